@@ hdl/smx_pkg.sv @@
package smx_pkg;

   localparam int MAX_COLS_DEF       = 64;
   localparam int EXP_TABLE_BITS_DEF = 8;
   localparam int LOG2E_Q16          = 94548;
   localparam int SUM_W              = 24;
   localparam int EXP_W              = 17;

   typedef struct packed {
      logic signed [15:0] logit;
      logic               row_end;
   } req_type;

   typedef struct packed {
      logic [15:0] probability;
      logic [5:0]  column;
      logic        final_res;
      logic        row_overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_EXP_RD,
      ST_EXP_CALC,
      ST_DIV_RD,
      ST_DIV_CALC,
      ST_DIV_RUN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear_row;
      logic clr_idx;
      logic inc_idx;
      logic rd_en;
      logic exp_start;
      logic exp_done_wr;
      logic div_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic exp_busy;
      logic div_busy;
      logic last_idx;
   } sts_type;

   // 2^(-2^-j) in Q0.32, j = 1..12
   function automatic logic [31:0] pow2_neg_frac(input logic [3:0] j);
      logic [31:0] r;
      case (j)
         4'd1:    r = 32'd3037000500;
         4'd2:    r = 32'd3611622603;
         4'd3:    r = 32'd3938502376;
         4'd4:    r = 32'd4112874773;
         4'd5:    r = 32'd4202935003;
         4'd6:    r = 32'd4248717344;
         4'd7:    r = 32'd4271771996;
         4'd8:    r = 32'd4283353946;
         4'd9:    r = 32'd4289156690;
         4'd10:   r = 32'd4292061010;
         4'd11:   r = 32'd4293513907;
         4'd12:   r = 32'd4294240540;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/smx_exp.sv @@
module smx_exp #(
   parameter int EXP_TABLE_BITS = smx_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] d,
   output logic        busy,
   output logic [16:0] result
);

   localparam int CW = $clog2(EXP_TABLE_BITS + 2);

   logic          busy_ff, busy_in;
   logic [CW-1:0] j_ff, j_in;
   logic [32:0]   m_ff, m_in;
   logic [31:0]   t_ff, t_in;
   logic [16:0]   res_ff, res_in;
   logic [32:0]   d_prod;
   logic [64:0]   mul;
   logic [15:0]   n;
   logic [32:0]   shifted;

   assign d_prod  = 33'(d) * 33'(smx_pkg::LOG2E_Q16) + 33'd128;
   assign mul     = 65'(m_ff) * 65'(smx_pkg::pow2_neg_frac(4'(j_ff))) + 65'h80000000;
   assign n       = t_ff[31:16];
   assign shifted = m_ff >> (6'd16 + 6'(n[4:0]));

   always_comb begin
      busy_in = busy_ff;
      j_in    = j_ff;
      m_in    = m_ff;
      t_in    = t_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         j_in    = CW'(1);
         m_in    = 33'h1_0000_0000;
         t_in    = 32'(d_prod >> 8);
      end else if (busy_ff) begin
         if (32'(j_ff) <= 32'(EXP_TABLE_BITS)) begin
            if (t_ff[5'd16 - 5'(j_ff)])
               m_in = 33'(mul >> 32);
            j_in = j_ff + CW'(1);
         end else begin
            busy_in = 1'b0;
            res_in  = (n > 16'd16) ? 17'd0 : shifted[16:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      j_ff   <= j_in;
      m_ff   <= m_in;
      t_ff   <= t_in;
      res_ff <= res_in;
   end

   assign busy   = busy_ff;
   assign result = res_ff;

endmodule

@@ hdl/smx_div.sv @@
module smx_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [40:0] num,
   input  logic [23:0] den,
   output logic        busy,
   output logic [15:0] quot
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [40:0] q_ff, q_in;
   logic [23:0] r_ff, r_in;
   logic [23:0] den_ff, den_in;
   logic [24:0] trial;

   assign trial = {r_ff, q_ff[40]};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd41;
         q_in    = num;
         r_in    = 24'd0;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            r_in = 24'(trial - {1'b0, den_ff});
            q_in = {q_ff[39:0], 1'b1};
         end else begin
            r_in = trial[23:0];
            q_in = {q_ff[39:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1)
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = (q_ff[40:16] != 25'd0) ? 16'hFFFF : q_ff[15:0];

endmodule

@@ hdl/smx_datapath.sv @@
module smx_datapath #(
   parameter int MAX_COLS       = smx_pkg::MAX_COLS_DEF,
   parameter int EXP_TABLE_BITS = smx_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  smx_pkg::req_type req_data,
   input  smx_pkg::cmd_type cmd,
   output smx_pkg::sts_type sts,
   output smx_pkg::rsp_type rsp_value
);

   localparam int AW = $clog2(MAX_COLS);
   localparam int CW = $clog2(MAX_COLS + 1);

   logic [15:0]        xstore [MAX_COLS];
   logic [16:0]        estore [MAX_COLS];
   logic [15:0]        x_rd_ff;
   logic [16:0]        e_rd_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [15:0] max_ff, max_in;
   logic [23:0]        sum_ff, sum_in;
   logic               ovf_ff, ovf_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [16:0]        exp_res;
   logic [15:0]        quot;
   logic [15:0]        diff;
   logic               store_en;
   logic               exp_busy;
   logic               div_busy;
   smx_pkg::rsp_type   out_ff, out_in;

   assign store_en = req_fire && (count_ff < CW'(MAX_COLS));
   assign diff     = 16'(max_ff - $signed(x_rd_ff));

   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      out_in   = out_ff;
      if (req_fire) begin
         if (store_en) begin
            count_in = count_ff + CW'(1);
            if (req_data.logit > max_ff)
               max_in = req_data.logit;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.clr_idx)
         idx_in = '0;
      else if (cmd.inc_idx)
         idx_in = idx_ff + CW'(1);
      if (cmd.exp_done_wr)
         sum_in = sum_ff + 24'(exp_res);
      if (cmd.out_load) begin
         out_in.probability  = quot;
         out_in.column       = 6'(idx_ff);
         out_in.final_res    = (idx_ff + CW'(1) == count_ff);
         out_in.row_overflow = ovf_ff;
      end
      if (cmd.clear_row) begin
         count_in = '0;
         max_in   = 16'sh8000;
         sum_in   = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= 16'sh8000;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         idx_ff   <= idx_in;
      end
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (store_en)
         xstore[count_ff[AW-1:0]] <= req_data.logit;
      if (cmd.exp_done_wr)
         estore[idx_ff[AW-1:0]] <= exp_res;
      if (cmd.rd_en) begin
         x_rd_ff <= xstore[idx_ff[AW-1:0]];
         e_rd_ff <= estore[idx_ff[AW-1:0]];
      end
   end

   smx_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.exp_start),
      .d      (diff),
      .busy   (exp_busy),
      .result (exp_res)
   );

   smx_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({e_rd_ff, 16'd0} + 41'(sum_ff >> 1)),
      .den   (sum_ff),
      .busy  (div_busy),
      .quot  (quot)
   );

   assign sts = '{exp_busy: exp_busy, div_busy: div_busy,
                  last_idx: (idx_ff + CW'(1) == count_ff)};
   assign rsp_value = out_ff;

endmodule

@@ hdl/smx_ctrl.sv @@
module smx_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_row_end,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  smx_pkg::sts_type sts,
   output smx_pkg::cmd_type cmd
);

   smx_pkg::state_type state_ff, state_in;
   logic               vld_ff, vld_in;
   logic               last_ff, last_in;

   always_comb begin
      state_in  = state_ff;
      vld_in    = vld_ff;
      last_in   = last_ff;
      cmd       = '0;
      req_stall = 1'b1;
      if (vld_ff && !rsp_stall)
         vld_in = 1'b0;
      case (state_ff)
         smx_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid && req_row_end) begin
               cmd.clr_idx = 1'b1;
               state_in    = smx_pkg::ST_EXP_RD;
            end
         end
         smx_pkg::ST_EXP_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = smx_pkg::ST_EXP_CALC;
            last_in   = sts.last_idx;
         end
         smx_pkg::ST_EXP_CALC: begin
            cmd.exp_start = 1'b1;
            state_in      = smx_pkg::ST_OUT;
         end
         smx_pkg::ST_OUT: begin
            if (!sts.exp_busy) begin
               cmd.exp_done_wr = 1'b1;
               if (last_ff) begin
                  cmd.clr_idx = 1'b1;
                  state_in    = smx_pkg::ST_DIV_RD;
               end else begin
                  cmd.inc_idx = 1'b1;
                  state_in    = smx_pkg::ST_EXP_RD;
               end
            end
         end
         smx_pkg::ST_DIV_RD: begin
            if (!vld_ff || !rsp_stall) begin
               cmd.rd_en = 1'b1;
               last_in   = sts.last_idx;
               state_in  = smx_pkg::ST_DIV_CALC;
            end
         end
         smx_pkg::ST_DIV_CALC: begin
            cmd.div_start = 1'b1;
            state_in      = smx_pkg::ST_DIV_RUN;
         end
         smx_pkg::ST_DIV_RUN: begin
            if (!sts.div_busy) begin
               cmd.out_load = 1'b1;
               vld_in       = 1'b1;
               if (last_ff) begin
                  cmd.clear_row = 1'b1;
                  state_in      = smx_pkg::ST_LOAD;
               end else begin
                  cmd.inc_idx = 1'b1;
                  state_in    = smx_pkg::ST_DIV_RD;
               end
            end
         end
         default: state_in = smx_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smx_pkg::ST_LOAD;
         vld_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid = vld_ff;

endmodule

@@ hdl/softmax_row_unit.sv @@
// softmax_row_unit: softmax over one row of signed Q8.8 logits.
// Input channel req_*: one logit per item, req_data.row_end marks the last.
// Logits are stored (up to MAX_COLS) while the row maximum is tracked; extra
// items are dropped and flag row_overflow on every result of that row.
// Loading takes one item per cycle. After the row_end item the unit stops
// taking items (req_stall high) and, per stored element:
//   exp pass: through a shared iterative exp unit (one table bit per
//     cycle), summing the results;
//   divide pass: through a restoring divider (41 quotient bits, one
//     per cycle), rounded and saturated at 65535.
// Elements pass through one at a time, and req_stall drops once the last
// result is loaded.
// Results leave on rsp_* in column order, rsp_data.final_res on the last.
// One output register; a stalled result holds and the divide pass waits
// until that register is free before reading the next element.
// Reset clears the row state and the control; the store needs no clearing.
module softmax_row_unit #(
   parameter int MAX_COLS       = smx_pkg::MAX_COLS_DEF,
   parameter int EXP_TABLE_BITS = smx_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  smx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output smx_pkg::rsp_type rsp_data
);

   smx_pkg::cmd_type cmd;
   smx_pkg::sts_type sts;

   smx_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_row_end (req_data.row_end),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   smx_datapath #(.MAX_COLS(MAX_COLS), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_valid && !req_stall),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_value (rsp_data)
   );

endmodule

@@ hdl/smx_checker.sv @@
module smx_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input smx_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input smx_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !rsp_valid || rsp_data.final_res)
      else $error("input taken while a row is being emitted");

   a_row_end_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.row_end |=> req_stall)
      else $error("input taken right after row end");

   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.final_res |=> req_stall)
      else $error("input taken before the row was emitted");

endmodule

bind softmax_row_unit smx_checker u_smx_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ tb/softmax_row_unit_tb.sv @@
`timescale 1ns / 100ps

module softmax_row_unit_tb;

   localparam int NCOLS = 64;
   localparam int TBITS = 8;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   smx_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   smx_pkg::rsp_type rsp_data;

   softmax_row_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // predictor state
   logic signed [15:0] row_logits [NCOLS];
   int unsigned        row_len;
   logic signed [15:0] row_peak;
   logic               row_dropped;

   smx_pkg::rsp_type prob_queue [$];
   int      errors = 0;
   int      rows_done = 0;
   int      items_sent = 0;
   int      results_seen = 0;
   bit      calm = 1'b0;

   localparam logic [31:0] FRAC_K [12] = '{
      32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
      32'd4202935003, 32'd4248717344, 32'd4271771996, 32'd4283353946,
      32'd4289156690, 32'd4292061010, 32'd4293513907, 32'd4294240540};

   function automatic logic [16:0] exp_of_gap(input logic [15:0] d);
      logic [63:0] t, n, m;
      t = ({48'd0, d} * 64'd94548 + 64'd128) >> 8;
      n = t >> 16;
      m = 64'd1 << 32;
      if (n > 16) return '0;
      for (int j = 1; j <= TBITS; j++)
         if (t[16 - j]) m = (m * {32'd0, FRAC_K[j - 1]} + 64'h8000_0000) >> 32;
      return 17'(m >> (16 + n));
   endfunction

   task automatic clear_row_model();
      row_len = 0;
      row_peak = -16'sd32768;
      row_dropped = 1'b0;
   endtask

   task automatic predict_row_item(input smx_pkg::req_type it);
      logic [16:0]      ev [NCOLS];
      logic [23:0]      total;
      logic [63:0]      p;
      smx_pkg::rsp_type r;
      if (row_len < NCOLS) begin
         row_logits[row_len] = it.logit;
         row_len++;
         if (it.logit > row_peak) row_peak = it.logit;
      end else begin
         row_dropped = 1'b1;
      end
      if (!it.row_end) return;
      total = '0;
      for (int k = 0; k < row_len; k++) begin
         ev[k] = exp_of_gap(16'(row_peak - row_logits[k]));
         total = total + 24'(ev[k]);
      end
      for (int k = 0; k < row_len; k++) begin
         p = ({47'd0, ev[k]} * 64'd65536 + {40'd0, total >> 1}) / {40'd0, total};
         if (p > 65535) p = 65535;
         r.probability = 16'(p);
         r.column = 6'(k);
         r.final_res = (k + 1 == row_len);
         r.row_overflow = row_dropped;
         prob_queue.push_back(r);
      end
      rows_done++;
      clear_row_model();
   endtask

   task automatic send_item(input logic signed [15:0] x, input logic last_i);
      if (!calm) begin
         while ($urandom_range(99) < 26) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_data <= '{logit: x, row_end: last_i};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_row_item('{logit: x, row_end: last_i});
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_row(input int len, input int mode);
      logic signed [15:0] x;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: x = 16'($urandom);
            1: x = 16'($urandom_range(1536)) - 16'sd768;
            default: x = 16'($urandom_range(64)) - 16'sd32;
         endcase
         send_item(x, i == len - 1);
      end
   endtask

   // receiver
   always @(negedge clock) begin
      if (!reset) rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
   end

   always @(posedge clock) begin
      smx_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (prob_queue.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            errors++;
         end else begin
            e = prob_queue.pop_front();
            if (rsp_data.probability !== e.probability) begin
               $error("probability exp %0d got %0d", e.probability, rsp_data.probability);
               errors++;
            end
            if (rsp_data.column !== e.column) begin
               $error("column exp %0d got %0d", e.column, rsp_data.column);
               errors++;
            end
            if (rsp_data.final_res !== e.final_res) begin
               $error("final_res exp %0d got %0d", e.final_res, rsp_data.final_res);
               errors++;
            end
            if (rsp_data.row_overflow !== e.row_overflow) begin
               $error("row_overflow exp %0d got %0d", e.row_overflow,
                      rsp_data.row_overflow);
               errors++;
            end
         end
      end
   end

   typedef struct {
      logic signed [15:0] logit;
      logic               row_end;
      logic               check;
      logic [15:0]        prob;
   } vec_type;

   vec_type vecs [] = '{
      '{16'sh7FFF, 1'b1, 1'b1, 16'd65535},
      '{16'sh8000, 1'b1, 1'b1, 16'd65535},
      '{16'sd0,    1'b1, 1'b1, 16'd65535},
      '{16'sd256,  1'b0, 1'b1, 16'd32768},
      '{16'sd256,  1'b1, 1'b1, 16'd32768},
      '{16'sh7FFF, 1'b0, 1'b1, 16'd65535},
      '{16'sh8000, 1'b1, 1'b1, 16'd0},
      '{16'sd0,    1'b0, 1'b0, 16'd0},
      '{16'sd177,  1'b0, 1'b0, 16'd0},
      '{-16'sd300, 1'b0, 1'b0, 16'd0},
      '{16'sh5555, 1'b0, 1'b0, 16'd0},
      '{16'shAAAA, 1'b1, 1'b0, 16'd0}
   };

   initial begin
      int               idx;
      smx_pkg::rsp_type tail;
      clear_row_model();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // expected value is the last result of the row ended by that item
      foreach (vecs[i]) begin
         idx = rows_done;
         send_item(vecs[i].logit, vecs[i].row_end);
         if (vecs[i].check && rows_done > idx) begin
            tail = prob_queue[prob_queue.size() - 1];
            if (tail.probability !== vecs[i].prob) begin
               $error("probability table exp %0d model %0d", vecs[i].prob,
                      tail.probability);
               errors++;
            end
         end
      end
      // full row then overflow, with dropped row_end
      send_row(NCOLS, 1);
      for (int i = 0; i < NCOLS; i++) send_item(16'($urandom), 1'b0);
      send_item(16'sh7FFF, 1'b0);
      send_item(16'sh8000, 1'b1);

      // hold off until drained
      req_valid <= 1'b0;
      @(negedge clock);
      while (prob_queue.size() != 0) @(negedge clock);

      calm = 1'b1;
      for (int r = 0; r < 6; r++) send_row($urandom_range(8, 1), r % 3);
      calm = 1'b0;

      while (items_sent < 290) begin
         case ($urandom_range(9))
            0: send_row(NCOLS + $urandom_range(4), $urandom_range(2));
            1: send_row($urandom_range(40, 9), $urandom_range(2));
            default: send_row($urandom_range(8, 1), $urandom_range(2));
         endcase
      end

      req_valid <= 1'b0;
      while (prob_queue.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("Sent %0d logits in %0d rows, checked %0d probabilities.",
               items_sent, rows_done, results_seen);
      $display("Covered extremes, single-element rows, full and overflowing rows.");
      if (errors == 0 && prob_queue.size() == 0)
         $display("PASS softmax_row_unit");
      else
         $display("FAIL softmax_row_unit");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL softmax_row_unit");
      $finish;
   end

endmodule

@@ files.f @@
hdl/smx_pkg.sv
hdl/smx_exp.sv
hdl/smx_div.sv
hdl/smx_datapath.sv
hdl/smx_ctrl.sv
hdl/softmax_row_unit.sv
hdl/smx_checker.sv
tb/softmax_row_unit_tb.sv
